FILE: rtl/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg - shared types and constants of the rgb to hsl pixel converter
// widths of the divider operands, reciprocal constants for the lightness
// scaling, and the records that travel down the pipeline beside the dividers
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int unsigned ChanW      = 8;
  localparam int unsigned SumW       = 9;
  localparam int unsigned SatNumW    = 16;
  localparam int unsigned SatDenW    = 9;
  localparam int unsigned HueNumW    = 14;
  localparam int unsigned HueDenW    = 8;
  localparam int unsigned QuoW       = 8;
  localparam int unsigned LxW        = 17;
  localparam int unsigned HueW       = 10;
  localparam int unsigned RgbTop     = 255;
  localparam int unsigned RgbSpan    = 2 * RgbTop;
  localparam int unsigned RecipShift = 26;
  localparam int unsigned RecipMul   = (1 << RecipShift) / RgbSpan;
  localparam int unsigned ProdW      = 35;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_chan_t;

  // operands of the three dividers
  typedef struct packed {
    logic [SatNumW-1:0] sat_num;
    logic [SatDenW-1:0] sat_den;
    logic [HueNumW-1:0] hue_num_a;
    logic [HueNumW-1:0] hue_num_b;
    logic [HueDenW-1:0] hue_den;
  } rth_div_in_t;

  // everything the back end needs besides the quotients
  typedef struct packed {
    max_chan_t        sel;
    logic             grey;
    logic             sat_den_zero;
    logic [QuoW-1:0]  light_est;
    logic [LxW-1:0]   light_x;
  } rth_side_t;

endpackage

FILE: rtl/rth_if.sv
// ----------------------------------------------------------------------------
// rth_if - pixel channels of the rgb to hsl converter
// valid/ready channels carrying one rgb word in and one hsl word out
// ----------------------------------------------------------------------------
interface rth_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsl_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

FILE: rtl/rth_front.sv
// ----------------------------------------------------------------------------
// rth_front - first two pipeline stages
// finds max/min and the largest channel, then forms divider operands and the
// lightness estimate
// ----------------------------------------------------------------------------
module rth_front
  import rth_pkg::*;
#(
  parameter int unsigned HSL_SCALE = 252
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [ChanW-1:0]  red,
  input  logic [ChanW-1:0]  green,
  input  logic [ChanW-1:0]  blue,
  output logic              out_valid,
  output rth_div_in_t       div_in,
  output rth_side_t         side
);

  localparam int unsigned     Sixth     = HSL_SCALE / 6;
  localparam int unsigned     HalfScale = HSL_SCALE / 2;
  localparam logic [LxW-1:0]  UpperThr  = LxW'((HalfScale + 1) * RgbSpan);
  localparam logic [ProdW-1:0] LightMul = ProdW'(HSL_SCALE) * ProdW'(RecipMul);
  localparam logic [ProdW-1:0] LightOff = ProdW'(RgbTop) * ProdW'(RecipMul);

  // stage 1
  logic [ChanW-1:0] hi, lo, na, nb;
  max_chan_t        sel;

  logic             valid1_r;
  logic [SumW-1:0]  sum1_r;
  logic [ChanW-1:0] diff1_r;
  logic [ChanW-1:0] na1_r;
  logic [ChanW-1:0] nb1_r;
  max_chan_t        sel1_r;

  always_comb begin
    hi = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    lo = red;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    // ties go to red first, then green
    if (red == hi) begin
      sel = MAX_RED;
      na  = hi - blue;
      nb  = hi - green;
    end else if (green == hi) begin
      sel = MAX_GREEN;
      na  = hi - red;
      nb  = hi - blue;
    end else begin
      sel = MAX_BLUE;
      na  = hi - green;
      nb  = hi - red;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
    end else if (en) begin
      valid1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum1_r  <= SumW'(hi) + SumW'(lo);
      diff1_r <= hi - lo;
      na1_r   <= na;
      nb1_r   <= nb;
      sel1_r  <= sel;
    end
  end

  // stage 2
  logic [LxW-1:0]     light_x;
  logic               upper;
  logic [SatDenW-1:0] sat_den;
  logic [ProdW-1:0]   light_prod;

  logic               valid2_r;
  rth_div_in_t        div_nxt, div_r;
  rth_side_t          side_nxt, side_r;

  always_comb begin
    light_x    = LxW'(sum1_r) * LxW'(HSL_SCALE) + LxW'(RgbTop);
    // lightness above half scale picks the upper saturation divisor
    upper      = (light_x >= UpperThr);
    sat_den    = upper ? (SatDenW'(RgbSpan) - SatDenW'(sum1_r)) : SatDenW'(sum1_r);
    light_prod = ProdW'(sum1_r) * LightMul + LightOff;

    div_nxt.sat_num   = SatNumW'(diff1_r) * SatNumW'(HSL_SCALE) + SatNumW'(sat_den >> 1);
    div_nxt.sat_den   = sat_den;
    div_nxt.hue_num_a = HueNumW'(na1_r) * HueNumW'(Sixth) + HueNumW'(diff1_r >> 1);
    div_nxt.hue_num_b = HueNumW'(nb1_r) * HueNumW'(Sixth) + HueNumW'(diff1_r >> 1);
    div_nxt.hue_den   = diff1_r;

    side_nxt.sel          = sel1_r;
    side_nxt.grey         = (diff1_r == '0);
    side_nxt.sat_den_zero = (sat_den == '0);
    side_nxt.light_est    = light_prod[RecipShift +: QuoW];
    side_nxt.light_x      = light_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid2_r <= 1'b0;
    end else if (en) begin
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r  <= div_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = valid2_r;
  assign div_in    = div_r;
  assign side      = side_r;

endmodule

FILE: rtl/rth_div.sv
// ----------------------------------------------------------------------------
// rth_div - pipelined restoring divider
// one quotient bit per stage, msb first; the quotient must fit in QUO_W bits
// ----------------------------------------------------------------------------
module rth_div
  import rth_pkg::*;
#(
  parameter int unsigned NUM_W = 16,
  parameter int unsigned DEN_W = 9,
  parameter int unsigned QUO_W = 8
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  localparam int unsigned WideW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_r [QUO_W-1];
  logic [DEN_W-1:0] den_r [QUO_W-1];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [WideW-1:0] trial;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = WideW'(den_in) << (QUO_W - 1 - k);
    assign fits  = (WideW'(rem_in) >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= {quo_in[QUO_W-2:0], fits};
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      logic [WideW-1:0] diff;

      assign diff = WideW'(rem_in) - trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= fits ? diff[NUM_W-1:0] : rem_in;
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

FILE: rtl/rth_back.sv
// ----------------------------------------------------------------------------
// rth_back - last stage and output register
// assembles hue with wrap-around, clamps saturation, fixes up lightness
// ----------------------------------------------------------------------------
module rth_back
  import rth_pkg::*;
#(
  parameter int unsigned HSL_SCALE = 252
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  rth_side_t        side,
  input  logic [QuoW-1:0]  sat_q,
  input  logic [QuoW-1:0]  hue_qa,
  input  logic [QuoW-1:0]  hue_qb,
  output logic             out_valid,
  output logic [7:0]       hue,
  output logic [7:0]       saturation,
  output logic [7:0]       lightness
);

  localparam logic [HueW-1:0] BaseGreen = HueW'(HSL_SCALE / 3);
  localparam logic [HueW-1:0] BaseBlue  = HueW'((2 * HSL_SCALE) / 3);
  localparam logic [HueW-1:0] ScaleHue  = HueW'(HSL_SCALE);
  localparam logic [QuoW-1:0] ScaleQ    = QuoW'(HSL_SCALE);

  logic [HueW-1:0]        base;
  logic signed [HueW-1:0] hue_raw;
  logic signed [HueW-1:0] hue_fix;
  logic [LxW-1:0]         light_rem;
  logic [QuoW-1:0]        light_nxt;
  logic [QuoW-1:0]        sat_nxt;
  logic [7:0]             hue_nxt;

  logic                   valid_r;
  logic [7:0]             hue_r;
  logic [7:0]             sat_r;
  logic [7:0]             light_r;

  always_comb begin
    unique case (side.sel)
      MAX_RED:   base = '0;
      MAX_GREEN: base = BaseGreen;
      MAX_BLUE:  base = BaseBlue;
      default:   base = '0;
    endcase

    hue_raw = HueW'(base) + HueW'(hue_qa) - HueW'(hue_qb);
    if (hue_raw < 0) begin
      hue_fix = hue_raw + $signed(ScaleHue);
    end else if (hue_raw > $signed(ScaleHue)) begin
      hue_fix = hue_raw - $signed(ScaleHue);
    end else begin
      hue_fix = hue_raw;
    end

    if (side.grey) begin
      hue_nxt = BaseBlue[7:0];
      sat_nxt = '0;
    end else begin
      hue_nxt = hue_fix[7:0];
      if (side.sat_den_zero) begin
        sat_nxt = '0;
      end else if (sat_q > ScaleQ) begin
        sat_nxt = ScaleQ;
      end else begin
        sat_nxt = sat_q;
      end
    end

    // reciprocal estimate is exact or one low
    light_rem = side.light_x - LxW'(side.light_est) * LxW'(RgbSpan);
    light_nxt = (light_rem >= LxW'(RgbSpan)) ? side.light_est + QuoW'(1) : side.light_est;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      light_r <= light_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign hue        = hue_r;
  assign saturation = sat_r;
  assign lightness  = light_r;

endmodule

FILE: rtl/rgb_to_hsl_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel - streaming rgb to hsl pixel converter
// converts an 8-bit rgb word per unstalled clock to hue, saturation, lightness
// ----------------------------------------------------------------------------
// usage:
//   in_pix carries red, green, blue; out_pix carries hue, saturation,
//   lightness, all on a 0..HSL_SCALE scale. both are valid/ready channels,
//   a word moves on a clock edge with valid and ready high.
//   from acceptance to out_pix.valid a word passes two front stages,
//   eight divider stages (one quotient bit each) and the output register.
//   throughput is one word per clock unless out_pix stalls; the eight-stage
//   restoring dividers for saturation and the two hue deltas set the depth.
//   the whole pipeline advances together: when the output register holds a
//   word that is not taken, every stage holds and in_pix.ready drops, so
//   nothing is lost or repeated. an empty output register keeps ready high.
//   a synchronous reset (rst_n low) clears all valid bits; no words are
//   in flight afterwards and no clearing time is needed.
// ----------------------------------------------------------------------------
module rgb_to_hsl_pixel
  import rth_pkg::*;
#(
  parameter int unsigned HSL_SCALE = 252
) (
  input  logic          clk,
  input  logic          rst_n,
  rth_rgb_if.sink       in_pix,
  rth_hsl_if.source     out_pix
);

  logic         en;
  logic         front_valid;
  rth_div_in_t  div_in;
  rth_side_t    front_side;
  logic [QuoW-1:0] sat_q, hue_qa, hue_qb;
  logic         back_valid;

  // side records delayed alongside the divider stages
  logic         vld_r  [QuoW];
  rth_side_t    side_r [QuoW];

  assign en           = !back_valid || out_pix.ready;
  assign in_pix.ready = en;

  rth_front #(.HSL_SCALE(HSL_SCALE)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_pix.valid),
    .red       (in_pix.red),
    .green     (in_pix.green),
    .blue      (in_pix.blue),
    .out_valid (front_valid),
    .div_in    (div_in),
    .side      (front_side)
  );

  rth_div #(.NUM_W(SatNumW), .DEN_W(SatDenW), .QUO_W(QuoW)) u_div_sat (
    .clk (clk),
    .en  (en),
    .num (div_in.sat_num),
    .den (div_in.sat_den),
    .quo (sat_q)
  );

  rth_div #(.NUM_W(HueNumW), .DEN_W(HueDenW), .QUO_W(QuoW)) u_div_hue_a (
    .clk (clk),
    .en  (en),
    .num (div_in.hue_num_a),
    .den (div_in.hue_den),
    .quo (hue_qa)
  );

  rth_div #(.NUM_W(HueNumW), .DEN_W(HueDenW), .QUO_W(QuoW)) u_div_hue_b (
    .clk (clk),
    .en  (en),
    .num (div_in.hue_num_b),
    .den (div_in.hue_den),
    .quo (hue_qb)
  );

  for (genvar k = 0; k < QuoW; k++) begin : g_side
    logic      vld_in;
    rth_side_t side_in;

    if (k == 0) begin : g_first
      assign vld_in  = front_valid;
      assign side_in = front_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_in;
      end
    end
  end

  rth_back #(.HSL_SCALE(HSL_SCALE)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (vld_r[QuoW-1]),
    .side       (side_r[QuoW-1]),
    .sat_q      (sat_q),
    .hue_qa     (hue_qa),
    .hue_qb     (hue_qb),
    .out_valid  (back_valid),
    .hue        (out_pix.hue),
    .saturation (out_pix.saturation),
    .lightness  (out_pix.lightness)
  );

  assign out_pix.valid = back_valid;

  a_out_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_pix.valid |-> (out_pix.hue <= 8'(HSL_SCALE)) &&
                      (out_pix.saturation <= 8'(HSL_SCALE)) &&
                      (out_pix.lightness <= 8'(HSL_SCALE)))
    else $error("hsl word out of range");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_pix.valid)
    else $error("output valid after reset");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_pix.valid |-> in_pix.ready)
    else $error("input stalled with empty output register");

  a_tail_reaches_out : assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[QuoW-1] |=> out_pix.valid)
    else $error("word lost between divider tail and output register");

endmodule
